/* rtl/core/hall_commutation_speed_estimator_top_defines.svh */
// Assertion macros shared by the Hall commutation speed estimator RTL.
`ifndef HALL_COMMUTATION_SPEED_ESTIMATOR_TOP_DEFINES_SVH
`define HALL_COMMUTATION_SPEED_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCSE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hcse_pkg.sv */
// Types, constants and commutation tables of the Hall commutation speed estimator.
package hcse_pkg;

    // Item command codes.
    localparam logic CMD_DRIVE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DUTY_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_SPEED_CONST = 2'd1;
    localparam logic [1:0] CFG_SPAN_CEIL   = 2'd2;

    // Configuration reset values.
    localparam logic [11:0] DUTY_LIMIT_RST  = 12'd1199;
    localparam logic [23:0] SPEED_CONST_RST = 24'd5000000;
    localparam logic [29:0] SPAN_CEIL_RST   = 30'd1000000000;

    // Shared divider geometry.
    localparam int DIV_DVD_W = 24;
    localparam int DIV_DVS_W = 30;
    localparam int DIV_CNT_W = 5;

    // Raw speed divides the 24-bit numerator, one quotient bit per step.
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RAW = 5'd24;

    // Divide by ten as a multiply by ceil(2^31 / 10) and a shift by 31.
    // It is exact for any magnitude below 2^30; the filter stays below 2^28.
    localparam logic [27:0] TEN_RECIP = 28'hCCCCCCD;
    localparam int          TEN_SHIFT = 31;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_SPAN,
        ST_RAW_GO,
        ST_RAW_WAIT,
        ST_FILT,
        ST_TEN_MUL,
        ST_TEN_APPLY,
        ST_RESULT
    } state_t;

    // Divider launch control.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctl_t;

    // High-side enable for a Hall code, forward or reverse rotation.
    function automatic logic [2:0] high_lookup(input logic fwd, input logic [2:0] hall);
        logic [2:0] h;
        begin
            unique case (hall)
                3'd0: h = 3'd0;
                3'd1: h = fwd ? 3'd4 : 3'd1;
                3'd2: h = fwd ? 3'd2 : 3'd4;
                3'd3: h = fwd ? 3'd2 : 3'd1;
                3'd4: h = fwd ? 3'd1 : 3'd2;
                3'd5: h = fwd ? 3'd4 : 3'd2;
                3'd6: h = fwd ? 3'd1 : 3'd4;
                3'd7: h = 3'd0;
            endcase
            return h;
        end
    endfunction

    // Low-side pattern for a Hall code; same in both directions.
    function automatic logic [2:0] low_lookup(input logic [2:0] hall);
        logic [2:0] l;
        begin
            unique case (hall)
                3'd0: l = 3'd0;
                3'd1: l = 3'd5;
                3'd2: l = 3'd6;
                3'd3: l = 3'd3;
                3'd4: l = 3'd3;
                3'd5: l = 3'd6;
                3'd6: l = 3'd5;
                3'd7: l = 3'd0;
            endcase
            return l;
        end
    endfunction

endpackage

/* rtl/core/hcse_div.sv */
// Bit-serial restoring divider used by the raw speed step.
module hcse_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hcse_pkg::div_ctl_t                 ctl,
    input  logic [hcse_pkg::DIV_DVD_W-1:0]     dividend,
    input  logic [hcse_pkg::DIV_DVS_W-1:0]     divisor,
    output logic                               busy,
    output logic                               done,
    output logic [hcse_pkg::DIV_DVD_W-1:0]     quotient
);

    logic [hcse_pkg::DIV_DVD_W-1:0] q_reg, q_next;
    logic [hcse_pkg::DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [hcse_pkg::DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [hcse_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [hcse_pkg::DIV_DVS_W:0]   trial;
    logic [hcse_pkg::DIV_DVS_W:0]   diff;
    logic                           fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, q_reg[hcse_pkg::DIV_DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = ctl.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[hcse_pkg::DIV_DVD_W-2:0], fits};
            rem_next = fits ? diff[hcse_pkg::DIV_DVS_W-1:0] : trial[hcse_pkg::DIV_DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == {{(hcse_pkg::DIV_CNT_W-1){1'b0}}, 1'b1}) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the operand registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/core/hall_commutation_speed_estimator_top.sv */
// Top level of the six-step Hall commutator with filtered speed estimate.
//
//  Channel   Prefix  Handshake          Moves
//  input     s_      s_valid/s_ready    one drive or tick command per transfer
//  result    m_      m_valid/m_ready    one result per accepted command
//  config    cfg_    cfg_valid/cfg_ready register index and write data
//
// A drive command steps through the drive and result states. A tick command steps
// through the span, divider launch, divider wait, filter, multiply, apply and
// result states and uses the bit-serial divider for the raw speed; the filter
// divides by ten with one reciprocal multiply. A zero span skips the divider.
// Reset is synchronous and active low; it loads the register defaults and clears
// the commutation and speed state. s_ready is high only while the sequencer is
// idle; a stalled result waits in the output register, and a second finished
// result holds the sequencer until that register drains.
module hall_commutation_speed_estimator_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [2:0]         s_hall,
    input  logic signed [15:0] s_pwm_ref,
    input  logic               s_enable,
    input  logic [15:0]        s_elapsed_us,
    input  logic               s_hall_edge,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_duty,
    output logic [2:0]         m_high_side,
    output logic [2:0]         m_low_side,
    output logic               m_direction,
    output logic               m_commutated,
    output logic signed [24:0] m_speed_rpm,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [29:0]        cfg_data
);

    `include "hall_commutation_speed_estimator_top_defines.svh"

    hcse_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [11:0] duty_limit_reg;
    logic [23:0] speed_const_reg;
    logic [29:0] span_ceil_reg;

    // Commutation and speed state.
    logic [2:0]         last_hall_reg, last_hall_next;
    logic               dir_reg, dir_next;
    logic [11:0]        duty_reg, duty_next;
    logic [2:0]         high_reg, high_next;
    logic [2:0]         low_reg, low_next;
    logic [29:0]        interval_reg, interval_next;
    logic signed [24:0] filt_reg, filt_next;
    logic               comm_reg, comm_next;

    // Captured command and intermediate results.
    logic        cmd_reg, hall_edge_reg, enable_reg;
    logic [2:0]  hall_reg;
    logic [15:0] pwm_reg, elapsed_reg;
    logic [23:0] raw_reg, raw_next;
    logic [27:0] acc_mag_reg, acc_mag_next;
    logic        acc_neg_reg, acc_neg_next;
    logic [24:0] ten_q_reg, ten_q_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic [11:0]        out_duty_reg;
    logic [2:0]         out_high_reg, out_low_reg;
    logic               out_dir_reg, out_comm_reg;
    logic signed [24:0] out_speed_reg;

    // Divider connection.
    hcse_pkg::div_ctl_t              div_ctl;
    logic [hcse_pkg::DIV_DVD_W-1:0]  div_dividend;
    logic [hcse_pkg::DIV_DVS_W-1:0]  div_divisor;
    logic                            div_busy, div_done;
    logic [hcse_pkg::DIV_DVD_W-1:0]  div_q;

    logic s_fire, out_load;

    // Drive arithmetic: magnitude, cap and direction of the request.
    logic [15:0] pwm_mag;
    logic [15:0] pwm_capped;
    logic        pwm_fwd;

    assign pwm_mag    = pwm_reg[15] ? (~pwm_reg + 16'd1) : pwm_reg;
    assign pwm_capped = (pwm_mag > {4'd0, duty_limit_reg}) ? {4'd0, duty_limit_reg} : pwm_mag;
    assign pwm_fwd    = !pwm_reg[15] && (pwm_reg != 16'd0);

    // Span accumulation with saturation at the ceiling.
    logic [30:0] span_sum;
    assign span_sum = {1'b0, interval_reg} + {15'd0, elapsed_reg};

    // Filter numerator 8*old + 2*(signed raw), its magnitude, and the reciprocal product.
    logic signed [24:0] raw_signed;
    logic signed [28:0] filt_acc;
    logic [28:0]        filt_acc_abs;
    logic [55:0]        ten_prod;

    assign raw_signed   = dir_reg ? $signed({1'b0, raw_reg}) : -$signed({1'b0, raw_reg});
    assign filt_acc     = $signed({filt_reg[24], filt_reg, 3'b000})
                        + $signed({{3{raw_signed[24]}}, raw_signed, 1'b0});
    assign filt_acc_abs = filt_acc[28] ? (~filt_acc + 29'd1) : filt_acc;
    assign ten_prod     = {28'd0, acc_mag_reg} * {28'd0, hcse_pkg::TEN_RECIP};

    assign s_fire = s_valid && s_ready;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hcse_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_cmd == hcse_pkg::CMD_TICK) ? hcse_pkg::ST_SPAN
                                                               : hcse_pkg::ST_DRIVE;
                end
            end
            hcse_pkg::ST_DRIVE:    state_next = hcse_pkg::ST_RESULT;
            hcse_pkg::ST_SPAN:     state_next = hcse_pkg::ST_RAW_GO;
            hcse_pkg::ST_RAW_GO: begin
                state_next = (interval_reg == 30'd0) ? hcse_pkg::ST_FILT
                                                     : hcse_pkg::ST_RAW_WAIT;
            end
            hcse_pkg::ST_RAW_WAIT: begin
                if (div_done) begin
                    state_next = hcse_pkg::ST_FILT;
                end
            end
            hcse_pkg::ST_FILT:      state_next = hcse_pkg::ST_TEN_MUL;
            hcse_pkg::ST_TEN_MUL:   state_next = hcse_pkg::ST_TEN_APPLY;
            hcse_pkg::ST_TEN_APPLY: state_next = hcse_pkg::ST_RESULT;
            hcse_pkg::ST_RESULT: begin
                if (out_load) begin
                    state_next = hcse_pkg::ST_IDLE;
                end
            end
            default:               state_next = hcse_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider launch.
    always_comb begin
        s_ready       = (state_reg == hcse_pkg::ST_IDLE);
        out_load      = (state_reg == hcse_pkg::ST_RESULT) && (!m_valid_reg || m_ready);
        div_ctl.start = 1'b0;
        div_ctl.steps = hcse_pkg::DIV_STEPS_RAW;
        div_dividend  = speed_const_reg;
        div_divisor   = interval_reg;
        unique case (state_reg)
            hcse_pkg::ST_RAW_GO: begin
                div_ctl.start = (interval_reg != 30'd0);
            end
            default: begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        last_hall_next = last_hall_reg;
        dir_next       = dir_reg;
        duty_next      = duty_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        interval_next  = interval_reg;
        filt_next      = filt_reg;
        comm_next      = comm_reg;
        raw_next       = raw_reg;
        acc_mag_next   = acc_mag_reg;
        acc_neg_next   = acc_neg_reg;
        ten_q_next     = ten_q_reg;
        unique case (state_reg)
            hcse_pkg::ST_IDLE: begin
                if (s_fire) begin
                    comm_next = 1'b0;
                end
            end
            hcse_pkg::ST_DRIVE: begin
                dir_next = pwm_fwd;
                if (!enable_reg) begin
                    duty_next = 12'd0;
                end else begin
                    duty_next = pwm_capped[11:0];
                    // A new Hall code steps the commutation.
                    if (hall_reg != last_hall_reg) begin
                        if (hcse_pkg::high_lookup(pwm_fwd, hall_reg) != 3'd0) begin
                            high_next = hcse_pkg::high_lookup(pwm_fwd, hall_reg);
                        end
                        low_next       = hcse_pkg::low_lookup(hall_reg);
                        last_hall_next = hall_reg;
                        comm_next      = 1'b1;
                    end
                end
            end
            hcse_pkg::ST_SPAN: begin
                interval_next = (span_sum > {1'b0, span_ceil_reg}) ? span_ceil_reg
                                                                   : span_sum[29:0];
            end
            hcse_pkg::ST_RAW_GO: begin
                // A zero span gives the constant itself.
                if (interval_reg == 30'd0) begin
                    raw_next = speed_const_reg;
                end
            end
            hcse_pkg::ST_RAW_WAIT: begin
                if (div_done) begin
                    raw_next = div_q;
                end
            end
            hcse_pkg::ST_FILT: begin
                acc_neg_next = filt_acc[28];
                acc_mag_next = filt_acc_abs[27:0];
            end
            hcse_pkg::ST_TEN_MUL: begin
                ten_q_next = ten_prod[hcse_pkg::TEN_SHIFT +: 25];
            end
            hcse_pkg::ST_TEN_APPLY: begin
                // The sign goes back on, so the division truncates toward zero.
                filt_next = acc_neg_reg ? -$signed(ten_q_reg) : $signed(ten_q_reg);
                if (hall_edge_reg) begin
                    interval_next = 30'd0;
                end
            end
            default: begin
                comm_next = comm_reg;
            end
        endcase
    end

    // Result valid holds until the downstream transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control, configuration and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= hcse_pkg::ST_IDLE;
            m_valid_reg     <= 1'b0;
            duty_limit_reg  <= hcse_pkg::DUTY_LIMIT_RST;
            speed_const_reg <= hcse_pkg::SPEED_CONST_RST;
            span_ceil_reg   <= hcse_pkg::SPAN_CEIL_RST;
            last_hall_reg   <= 3'd0;
            dir_reg         <= 1'b0;
            duty_reg        <= 12'd0;
            high_reg        <= 3'd0;
            low_reg         <= 3'd0;
            interval_reg    <= 30'd0;
            filt_reg        <= 25'sd0;
            comm_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            last_hall_reg <= last_hall_next;
            dir_reg       <= dir_next;
            duty_reg      <= duty_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            interval_reg  <= interval_next;
            filt_reg      <= filt_next;
            comm_reg      <= comm_next;
            // Configuration transfer; unknown indexes are dropped.
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    hcse_pkg::CFG_DUTY_LIMIT:  duty_limit_reg  <= cfg_data[11:0];
                    hcse_pkg::CFG_SPEED_CONST: speed_const_reg <= cfg_data[23:0];
                    hcse_pkg::CFG_SPAN_CEIL:   span_ceil_reg   <= cfg_data;
                    default:                   duty_limit_reg  <= duty_limit_reg;
                endcase
            end
        end
    end

    // Payload registers: captured command, intermediates and result.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg       <= s_cmd;
            hall_reg      <= s_hall;
            pwm_reg       <= s_pwm_ref;
            enable_reg    <= s_enable;
            elapsed_reg   <= s_elapsed_us;
            hall_edge_reg <= s_hall_edge;
        end
        raw_reg     <= raw_next;
        acc_mag_reg <= acc_mag_next;
        acc_neg_reg <= acc_neg_next;
        ten_q_reg   <= ten_q_next;
        if (out_load) begin
            out_duty_reg  <= duty_reg;
            out_high_reg  <= high_reg;
            out_low_reg   <= low_reg;
            out_dir_reg   <= dir_reg;
            out_comm_reg  <= comm_reg && (cmd_reg == hcse_pkg::CMD_DRIVE);
            out_speed_reg <= filt_reg;
        end
    end

    hcse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_duty       = out_duty_reg;
    assign m_high_side  = out_high_reg;
    assign m_low_side   = out_low_reg;
    assign m_direction  = out_dir_reg;
    assign m_commutated = out_comm_reg;
    assign m_speed_rpm  = out_speed_reg;

    // The divider only runs while the sequencer waits on it.
    `HCSE_ASSERT_IMP(a_div_owned, aclk, aresetn, div_busy, (state_reg == hcse_pkg::ST_RAW_WAIT), "divider busy outside a wait state")
    // At most one high-side switch is ever enabled.
    `HCSE_ASSERT_IMP(a_high_onehot, aclk, aresetn, m_valid, $onehot0(m_high_side), "high side not one-hot")
    // A command in progress blocks the next input transfer.
    `HCSE_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_fire, !s_ready, "input taken while busy")
    // A commutation step only comes from an enabled drive command.
    `HCSE_ASSERT_IMP(a_comm_drive, aclk, aresetn, out_load && comm_reg, (cmd_reg == hcse_pkg::CMD_DRIVE && enable_reg), "commutation without enabled drive")

endmodule

/* verif/tb.sv */
// Self-checking testbench for the Hall commutation speed estimator top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One command as presented on the input channel.
    typedef struct packed {
        logic               cmd;
        logic [2:0]         hall;
        logic signed [15:0] pwm_ref;
        logic               enable;
        logic [15:0]        elapsed_us;
        logic               hall_edge;
    } motor_cmd_t;

    // One result as seen on the output channel.
    typedef struct packed {
        logic [11:0]        duty;
        logic [2:0]         high_side;
        logic [2:0]         low_side;
        logic               direction;
        logic               commutated;
        logic signed [24:0] speed_rpm;
    } motor_out_t;

    // Register index that the block must ignore.
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    // Commutation tables packed three bits per Hall code, code 0 at the bottom.
    localparam logic [23:0] FWD_HIGH = {3'd0, 3'd1, 3'd4, 3'd1, 3'd2, 3'd2, 3'd4, 3'd0};
    localparam logic [23:0] REV_HIGH = {3'd0, 3'd4, 3'd2, 3'd2, 3'd1, 3'd4, 3'd1, 3'd0};
    localparam logic [23:0] LOW_SIDE = {3'd0, 3'd5, 3'd6, 3'd3, 3'd3, 3'd6, 3'd5, 3'd0};
    // Hall sequence of a forward turning rotor, step 0 at the bottom.
    localparam logic [17:0] HALL_ORDER = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    localparam int HOLD_CYCLES = 400;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_cmd = hcse_pkg::CMD_DRIVE;
    logic [2:0]         s_hall = '0;
    logic signed [15:0] s_pwm_ref = '0;
    logic               s_enable = 1'b0;
    logic [15:0]        s_elapsed_us = '0;
    logic               s_hall_edge = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [11:0]        m_duty;
    logic [2:0]         m_high_side;
    logic [2:0]         m_low_side;
    logic               m_direction;
    logic               m_commutated;
    logic signed [24:0] m_speed_rpm;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = hcse_pkg::CFG_DUTY_LIMIT;
    logic [29:0]        cfg_data = '0;

    hall_commutation_speed_estimator_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_hall       (s_hall),
        .s_pwm_ref    (s_pwm_ref),
        .s_enable     (s_enable),
        .s_elapsed_us (s_elapsed_us),
        .s_hall_edge  (s_hall_edge),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty       (m_duty),
        .m_high_side  (m_high_side),
        .m_low_side   (m_low_side),
        .m_direction  (m_direction),
        .m_commutated (m_commutated),
        .m_speed_rpm  (m_speed_rpm),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Commands waiting to be driven, and results expected in order.
    motor_cmd_t cmd_q[$];
    motor_out_t motor_out_q[$];
    motor_cmd_t on_bus = '0;

    int  items_queued = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    bit  idle_on = 1'b1;
    bit  hold_tog = 1'b0;
    bit  hold_seen = 1'b0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    int  hold_left = 0;

    // Mirrored registers.
    logic [11:0] lim_duty;
    logic [23:0] k_speed;
    logic [29:0] span_max;

    // Mirrored commutation and speed state.
    logic [2:0]  st_last_hall;
    logic        st_dir;
    logic [11:0] st_duty;
    logic [2:0]  st_high;
    logic [2:0]  st_low;
    logic [29:0] st_span;
    int          st_speed;

    // Rotor model that shapes well-formed command sequences.
    int rot_step = 0;
    bit rot_fwd = 1'b1;
    int rot_mag = 800;
    bit rot_moved = 1'b0;

    // Clock: 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // Works out the phase pattern and speed estimate after one command.
    function automatic motor_out_t predict_motor_out(input motor_cmd_t c);
        motor_out_t r;
        int         ref_val;
        int         mag;
        longint     span_sum;
        longint     raw;
        longint     filt_acc;
        logic [2:0] hi;
        r.commutated = 1'b0;
        if (c.cmd == hcse_pkg::CMD_DRIVE) begin
            ref_val = c.pwm_ref;
            mag = (ref_val < 0) ? -ref_val : ref_val;
            st_dir = (ref_val > 0);
            if (mag > int'(lim_duty)) mag = lim_duty;
            if (!c.enable) begin
                // Disabled: duty drops to zero and the phase pattern is frozen.
                st_duty = '0;
            end else begin
                st_duty = mag[11:0];
                if (c.hall != st_last_hall) begin
                    hi = st_dir ? FWD_HIGH[c.hall*3 +: 3] : REV_HIGH[c.hall*3 +: 3];
                    // Invalid Hall codes leave the high side alone.
                    if (hi != '0) st_high = hi;
                    st_low = LOW_SIDE[c.hall*3 +: 3];
                    st_last_hall = c.hall;
                    r.commutated = 1'b1;
                end
            end
        end else begin
            span_sum = longint'(st_span) + c.elapsed_us;
            st_span = (span_sum > span_max) ? span_max : span_sum[29:0];
            raw = (st_span == '0) ? longint'(k_speed) : longint'(k_speed / st_span);
            if (!st_dir) raw = -raw;
            filt_acc = longint'(st_speed) * 8 + raw * 2;
            st_speed = int'(filt_acc / 10);
            if (c.hall_edge) st_span = '0;
        end
        r.duty = st_duty;
        r.high_side = st_high;
        r.low_side = st_low;
        r.direction = st_dir;
        r.speed_rpm = st_speed[24:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // A command with every field random.
    function automatic motor_cmd_t noise_cmd();
        motor_cmd_t c;
        c.cmd = 1'($urandom_range(0, 1));
        c.hall = 3'($urandom_range(0, 7));
        c.pwm_ref = 16'($urandom);
        c.enable = 1'($urandom_range(0, 1));
        c.elapsed_us = 16'($urandom);
        c.hall_edge = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Next command of a turning rotor: drives follow the Hall sequence,
    // ticks report an edge whenever the rotor moved since the last tick.
    function automatic motor_cmd_t rotor_cmd();
        motor_cmd_t c;
        c = noise_cmd();
        if ($urandom_range(0, 29) == 0) rot_fwd = ~rot_fwd;
        if ($urandom_range(0, 9) == 0) begin
            rot_mag = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32768)
                                                  : $urandom_range(0, 1500);
        end
        if ($urandom_range(0, 1) == 0) begin
            c.cmd = hcse_pkg::CMD_DRIVE;
            if ($urandom_range(0, 3) != 0) begin
                rot_step = rot_fwd ? (rot_step + 1) % 6 : (rot_step + 5) % 6;
                rot_moved = 1'b1;
            end
            c.hall = HALL_ORDER[rot_step*3 +: 3];
            c.pwm_ref = rot_fwd ? 16'((rot_mag > 32767) ? 32767 : rot_mag) : 16'(-rot_mag);
            c.enable = ($urandom_range(0, 19) != 0);
        end else begin
            c.cmd = hcse_pkg::CMD_TICK;
            c.elapsed_us = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 3000));
            c.hall_edge = rot_moved;
            rot_moved = 1'b0;
        end
        return c;
    endfunction

    function automatic motor_cmd_t make_drive(input logic [2:0] hall, input int pwm,
                                              input logic en);
        motor_cmd_t c;
        c = noise_cmd();
        c.cmd = hcse_pkg::CMD_DRIVE;
        c.hall = hall;
        c.pwm_ref = 16'(pwm);
        c.enable = en;
        return c;
    endfunction

    function automatic motor_cmd_t make_tick(input int elapsed, input logic edge_seen);
        motor_cmd_t c;
        c = noise_cmd();
        c.cmd = hcse_pkg::CMD_TICK;
        c.elapsed_us = 16'(elapsed);
        c.hall_edge = edge_seen;
        return c;
    endfunction

    task automatic push_cmd(input motor_cmd_t c);
        cmd_q.push_back(c);
        items_queued++;
    endtask

    task automatic queue_random(input int count);
        @(negedge aclk);
        repeat (count) push_cmd(($urandom_range(0, 4) == 0) ? noise_cmd() : rotor_cmd());
    endtask

    // Waits until every queued command has been taken and answered.
    task automatic drain();
        while (items_accepted != items_queued || results_seen < items_accepted)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // One register write; the mirror follows at the transfer.
    task automatic cfg_write(input logic [1:0] idx, input logic [29:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hcse_pkg::CFG_DUTY_LIMIT:  lim_duty = val[11:0];
            hcse_pkg::CFG_SPEED_CONST: k_speed = val[23:0];
            hcse_pkg::CFG_SPAN_CEIL:   span_max = val;
            default: ;
        endcase
    endtask

    // Input driver: predicts each transfer and presents the next command.
    always @(posedge aclk) begin : cmd_driver
        motor_cmd_t nxt_cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                motor_out_q.push_back(predict_motor_out(on_bus));
                items_accepted++;
                tx_gap = idle_on ? pick_gap() : 0;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    nxt_cmd = cmd_q.pop_front();
                    on_bus <= nxt_cmd;
                    s_cmd <= nxt_cmd.cmd;
                    s_hall <= nxt_cmd.hall;
                    s_pwm_ref <= nxt_cmd.pwm_ref;
                    s_enable <= nxt_cmd.enable;
                    s_elapsed_us <= nxt_cmd.elapsed_us;
                    s_hall_edge <= nxt_cmd.hall_edge;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
            hold_left = 0;
            hold_seen = hold_tog;
        end else begin
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                rx_stall = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result monitor: each transfer is compared with the oldest expectation.
    always @(posedge aclk) begin : result_monitor
        motor_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (motor_out_q.size() == 0) begin
                $error("result transfer with no expectation pending");
                mismatch_count++;
            end else begin
                want = motor_out_q.pop_front();
                check_field("duty", want.duty, m_duty);
                check_field("high_side", want.high_side, m_high_side);
                check_field("low_side", want.low_side, m_low_side);
                check_field("direction", want.direction, m_direction);
                check_field("commutated", want.commutated, m_commutated);
                check_field("speed_rpm", want.speed_rpm, m_speed_rpm);
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int base;
        lim_duty = hcse_pkg::DUTY_LIMIT_RST;
        k_speed = hcse_pkg::SPEED_CONST_RST;
        span_max = hcse_pkg::SPAN_CEIL_RST;
        st_last_hall = '0;
        st_dir = 1'b0;
        st_duty = '0;
        st_high = '0;
        st_low = '0;
        st_span = '0;
        st_speed = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: duty extremes and capping, every Hall code both ways,
        // invalid codes, disabled drive, zero and full tick spans.
        @(negedge aclk);
        push_cmd(make_drive(3'd0, 0, 1'b1));
        push_cmd(make_drive(3'd1, 32767, 1'b1));
        push_cmd(make_drive(3'd3, 1200, 1'b1));
        push_cmd(make_drive(3'd2, 1199, 1'b1));
        push_cmd(make_drive(3'd6, 1, 1'b1));
        push_cmd(make_drive(3'd4, 100, 1'b1));
        push_cmd(make_drive(3'd5, 500, 1'b1));
        push_cmd(make_tick(0, 1'b0));
        push_cmd(make_tick(65535, 1'b1));
        push_cmd(make_tick(1000, 1'b0));
        push_cmd(make_drive(3'd7, 300, 1'b1));
        push_cmd(make_drive(3'd7, 300, 1'b1));
        push_cmd(make_drive(3'd0, -32768, 1'b1));
        push_cmd(make_drive(3'd1, -1, 1'b1));
        push_cmd(make_drive(3'd5, -1199, 1'b0));
        push_cmd(make_drive(3'd5, -600, 1'b1));
        push_cmd(make_drive(3'd4, -700, 1'b1));
        push_cmd(make_drive(3'd6, -700, 1'b1));
        push_cmd(make_drive(3'd2, -700, 1'b1));
        push_cmd(make_drive(3'd3, -700, 1'b1));
        push_cmd(make_tick(2000, 1'b0));
        push_cmd(make_tick(65535, 1'b1));
        push_cmd(make_drive(3'd3, 0, 1'b1));
        push_cmd(make_tick(40000, 1'b0));
        push_cmd(make_drive(3'd2, 32767, 1'b0));
        push_cmd(make_tick(0, 1'b1));
        drain();

        // Upper register extremes.
        cfg_write(hcse_pkg::CFG_DUTY_LIMIT, 30'd4095);
        cfg_write(hcse_pkg::CFG_SPEED_CONST, 30'd16777215);
        cfg_write(hcse_pkg::CFG_SPAN_CEIL, 30'h3FFF_FFFF);
        queue_random(200);
        drain();

        // Lower extremes; the receiver holds off while commands keep coming.
        cfg_write(hcse_pkg::CFG_DUTY_LIMIT, 30'd0);
        cfg_write(hcse_pkg::CFG_SPEED_CONST, 30'd1);
        cfg_write(hcse_pkg::CFG_SPAN_CEIL, 30'd1);
        base = items_queued;
        queue_random(150);
        while (items_accepted < base + 10) @(negedge aclk);
        hold_tog = ~hold_tog;
        drain();

        // Zero ceiling and constant, upper data bits ignored, unused index,
        // and a stretch with no idling on either side.
        cfg_write(hcse_pkg::CFG_DUTY_LIMIT, 30'($urandom));
        cfg_write(hcse_pkg::CFG_SPEED_CONST, {6'h2A, 24'h0});
        cfg_write(hcse_pkg::CFG_SPAN_CEIL, 30'd0);
        cfg_write(CFG_UNUSED_IDX, 30'($urandom));
        @(negedge aclk);
        idle_on = 1'b0;
        queue_random(100);
        drain();
        idle_on = 1'b1;

        // Random settings with a low ceiling so the span saturates.
        cfg_write(hcse_pkg::CFG_DUTY_LIMIT, 30'($urandom_range(0, 4095)));
        cfg_write(hcse_pkg::CFG_SPEED_CONST, 30'($urandom_range(1, 16777215)));
        cfg_write(hcse_pkg::CFG_SPAN_CEIL, 30'($urandom_range(20000, 300000)));
        queue_random(200);
        drain();

        // Back to the reset settings.
        cfg_write(hcse_pkg::CFG_DUTY_LIMIT, 30'(hcse_pkg::DUTY_LIMIT_RST));
        cfg_write(hcse_pkg::CFG_SPEED_CONST, 30'(hcse_pkg::SPEED_CONST_RST));
        cfg_write(hcse_pkg::CFG_SPAN_CEIL, 30'(hcse_pkg::SPAN_CEIL_RST));
        queue_random(150);
        drain();

        // Let any stray result show up before the verdict.
        repeat (100) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/hcse_pkg.sv
rtl/core/hcse_div.sv
rtl/core/hall_commutation_speed_estimator_top.sv
verif/tb.sv
